FILE: rtl/tccd_pkg.sv
package tccd_pkg;

  // Symbol averaging and offset tracking
  localparam int OFFSET_WINDOW = 287;
  localparam int WCNT_W = 9;
  localparam logic [15:0] RECIP3 = 16'd43691;   // ceil(2^17 / 3)
  localparam logic signed [15:0] WIN_MIN_INIT = 16'sh7FFF;
  localparam logic signed [15:0] WIN_MAX_INIT = 16'sh8000;

  // Bit history and frame layout
  localparam int HIST_W = 320;
  localparam int WORD_W = 40;
  localparam logic [47:0] SYNC_WORD = 48'h5555_5712_5555;

  // Command decoding
  localparam logic [7:0] ESK_XOR = 8'hA0;
  localparam logic [7:0] VOICE_ESK = 8'h18;
  localparam logic [7:0] VOICE_PLAIN = 8'hEE;
  localparam logic [7:0] PEER_COMMAND = 8'hF8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESK_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_CHANNEL = 2'd1;
  localparam int CFG_DATA_W = 5;

  // Frame queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic signed [15:0] sample_c;
  } sample_t;

  typedef struct packed {
    logic               repeat_ok;
    logic [7:0]         command;
    logic [3:0]         status;
    logic [2:0]         channel;
    logic               voice_grant;
    logic               peer_valid;
    logic [7:0]         peer_id;
    logic [14:0]        talkgroup;
    logic [19:0]        sender;
    logic [10:0]        fleet_code;
    logic [9:0]         site_id;
    logic signed [15:0] dc_offset;
  } result_t;

  typedef struct packed {
    logic               repeat_ok;
    logic               w1_eq_w4;
    logic [WORD_W-1:0]  w1;
    logic [19:0]        sender;
    logic [10:0]        fleet_code;
    logic [9:0]         site_id;
    logic signed [15:0] dc_offset;
  } frame_t;

  typedef struct packed {
    logic       esk_mode;
    logic [4:0] control_channel;
  } cfg_t;

endpackage

FILE: rtl/tccd_front.sv
module tccd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  tccd_pkg::sample_t   sample,
  input  logic                q_full,
  output logic                q_push,
  output tccd_pkg::frame_t    q_frame
);

  logic adv;

  // Stage A: sum and magnitude
  logic signed [17:0] sum;
  logic [16:0]        mag_next;
  logic               a_valid;
  logic               a_neg;
  logic [16:0]        a_mag;

  // Stage B: divide by three through the reciprocal
  logic [32:0] prod;
  logic        b_valid;
  logic        b_neg;
  logic [15:0] b_q;

  // Stage C: offset window and slicer
  logic signed [15:0]        avg;
  logic signed [15:0]        mn;
  logic signed [15:0]        mx;
  logic [tccd_pkg::WCNT_W-1:0] cnt_inc;
  logic                      win_end;
  logic signed [16:0]        mid_sum;
  logic signed [16:0]        half_sum;
  logic signed [15:0]        threshold_next;
  logic                      slice_bit;
  logic signed [15:0]        threshold;
  logic signed [15:0]        win_min;
  logic signed [15:0]        win_max;
  logic [tccd_pkg::WCNT_W-1:0] win_count;
  logic [tccd_pkg::HIST_W-1:0] hist;
  logic                      c_valid;

  // Stage D: sync detection and word extraction
  logic                        sync_hit;
  logic [tccd_pkg::WORD_W-1:0] w1;
  logic [tccd_pkg::WORD_W-1:0] w3;
  logic [tccd_pkg::WORD_W-1:0] w4;
  logic [tccd_pkg::WORD_W-1:0] w6;

  // The whole pipeline moves together; hold it only while the queue is full
  assign adv = !q_full;
  assign sample_ready = adv;

  always_comb begin
    sum = {{2{sample.sample_a[15]}}, sample.sample_a}
        + {{2{sample.sample_b[15]}}, sample.sample_b}
        + {{2{sample.sample_c[15]}}, sample.sample_c};
    mag_next = sum[17] ? 17'(-sum) : 17'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_neg <= sum[17];
      a_mag <= mag_next;
    end
  end

  // Exact floor(x / 3) for every 17-bit magnitude
  assign prod = 33'(a_mag) * 33'(tccd_pkg::RECIP3);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_neg <= a_neg;
      b_q   <= prod[32:17];
    end
  end

  always_comb begin
    avg      = b_neg ? 16'(-b_q) : b_q;
    mn       = (avg < win_min) ? avg : win_min;
    mx       = (avg > win_max) ? avg : win_max;
    cnt_inc  = win_count + 1'b1;
    win_end  = cnt_inc >= tccd_pkg::WCNT_W'(tccd_pkg::OFFSET_WINDOW);
    mid_sum  = {mn[15], mn} + {mx[15], mx};
    // Round the halved sum toward zero
    half_sum = mid_sum + {16'b0, mid_sum[16]};
    threshold_next = win_end ? half_sum[16:1] : threshold;
    slice_bit = avg < threshold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      win_min   <= tccd_pkg::WIN_MIN_INIT;
      win_max   <= tccd_pkg::WIN_MAX_INIT;
      win_count <= '0;
      hist      <= '0;
      c_valid   <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
      if (b_valid) begin
        threshold <= threshold_next;
        hist      <= {hist[tccd_pkg::HIST_W-2:0], slice_bit};
        if (win_end) begin
          win_min   <= tccd_pkg::WIN_MIN_INIT;
          win_max   <= tccd_pkg::WIN_MAX_INIT;
          win_count <= '0;
        end else begin
          win_min   <= mn;
          win_max   <= mx;
          win_count <= cnt_inc;
        end
      end
    end
  end

  always_comb begin
    sync_hit = hist[319:272] == tccd_pkg::SYNC_WORD;
    w1 = hist[271:232];
    w3 = hist[191:152];
    w4 = hist[151:112];
    w6 = hist[71:32];
    q_frame.repeat_ok  = (w1 == w3) && (w4 == w6);
    q_frame.w1_eq_w4   = w1 == w4;
    q_frame.w1         = w1;
    q_frame.sender     = w4[31:12];
    q_frame.fleet_code = hist[254:244];
    q_frame.site_id    = hist[147:138];
    q_frame.dc_offset  = threshold;
  end

  // Drop symbols that do not complete a sync pattern
  assign q_push = adv && c_valid && sync_hit;

endmodule

FILE: rtl/tccd_queue.sv
module tccd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tccd_pkg::frame_t  push_frame,
  input  logic              pop,
  output logic              full,
  output logic              avail,
  output tccd_pkg::frame_t  head
);

  tccd_pkg::frame_t          entries [tccd_pkg::QUEUE_DEPTH];
  logic [tccd_pkg::QPTR_W-1:0] wr_ptr;
  logic [tccd_pkg::QPTR_W-1:0] rd_ptr;
  logic [tccd_pkg::QCNT_W-1:0] count;

  assign full  = count == tccd_pkg::QCNT_W'(tccd_pkg::QUEUE_DEPTH);
  assign avail = count != '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/tccd_back.sv
module tccd_back (
  input  logic              clk,
  input  logic              rst,
  input  tccd_pkg::cfg_t    cfg,
  input  logic              q_avail,
  input  tccd_pkg::frame_t  q_head,
  output logic              q_pop,
  output logic              result_valid,
  input  logic              result_ready,
  output tccd_pkg::result_t result
);

  logic [7:0]  held_command;
  logic [3:0]  held_status;
  logic [2:0]  held_channel;
  logic [14:0] held_group;
  logic [19:0] held_sender;

  logic [7:0]  held_command_next;
  logic [3:0]  held_status_next;
  logic [2:0]  held_channel_next;
  logic [14:0] held_group_next;
  logic [19:0] held_sender_next;
  logic [7:0]  xmask;
  logic [7:0]  voice_cmd;
  logic [7:0]  peer;
  logic        grant;
  logic        peer_ok;
  tccd_pkg::result_t result_next;

  // Take a frame whenever the output register is free or being drained
  assign q_pop = q_avail && (!result_valid || result_ready);

  always_comb begin
    xmask     = cfg.esk_mode ? tccd_pkg::ESK_XOR : 8'h00;
    voice_cmd = cfg.esk_mode ? tccd_pkg::VOICE_ESK : tccd_pkg::VOICE_PLAIN;
    peer      = q_head.w1[19:12];

    // Keep the old command fields when the repeats disagree
    if (q_head.repeat_ok) begin
      held_command_next = q_head.w1[39:32] ^ xmask;
      held_status_next  = q_head.w1[24:21];
      held_channel_next = q_head.w1[31:29];
    end else begin
      held_command_next = held_command;
      held_status_next  = held_status;
      held_channel_next = held_channel;
    end

    grant = (held_command_next == voice_cmd) && (held_channel_next != 3'd0)
         && ({2'b00, held_channel_next} != cfg.control_channel);
    peer_ok = (held_command_next == tccd_pkg::PEER_COMMAND) && q_head.w1_eq_w4
           && (peer != 8'd0);

    if (grant && q_head.repeat_ok) begin
      held_group_next  = q_head.w1[26:12];
      held_sender_next = q_head.sender;
    end else begin
      held_group_next  = held_group;
      held_sender_next = held_sender;
    end

    result_next.repeat_ok   = q_head.repeat_ok;
    result_next.command     = held_command_next;
    result_next.status      = held_status_next;
    result_next.channel     = held_channel_next;
    result_next.voice_grant = grant;
    result_next.peer_valid  = peer_ok;
    result_next.peer_id     = peer;
    result_next.talkgroup   = held_group_next;
    result_next.sender      = held_sender_next;
    result_next.fleet_code  = q_head.fleet_code;
    result_next.site_id     = q_head.site_id;
    result_next.dc_offset   = q_head.dc_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_command <= '0;
      held_status  <= '0;
      held_channel <= '0;
      held_group   <= '0;
      held_sender  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        held_command <= held_command_next;
        held_status  <= held_status_next;
        held_channel <= held_channel_next;
        held_group   <= held_group_next;
        held_sender  <= held_sender_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= result_next;
    end
  end

endmodule

FILE: rtl/trunk_control_channel_decoder_top.sv
// Control-channel decoder: takes one symbol (three signed demodulator samples)
// per clock and emits one result per detected sync word. Symbols enter a
// four-stage front pipeline (sum, divide by three, offset window and slicer,
// sync check), so sample_ready stays high and a new symbol is taken every
// cycle unless the four-entry frame queue is full; the result for the symbol
// that completes the sync pattern goes through the queue and is held in an output
// register until transferred. The slicing threshold (dc_offset) is refreshed to
// the window midpoint every 287 symbols. Configuration writes are always taken
// (cfg_ready is tied high): index 0 sets esk_mode from cfg_data bit 0, index 1
// sets control_channel, other indexes are ignored; write only while idle.
module trunk_control_channel_decoder_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  tccd_pkg::sample_t                   sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output tccd_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tccd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tccd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tccd_pkg::cfg_t   cfg;
  tccd_pkg::frame_t push_frame;
  tccd_pkg::frame_t head_frame;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_avail;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.esk_mode        <= 1'b1;
      cfg.control_channel <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tccd_pkg::CFG_ESK_MODE:        cfg.esk_mode <= cfg_data[0];
        tccd_pkg::CFG_CONTROL_CHANNEL: cfg.control_channel <= cfg_data;
        default:                       cfg <= cfg;
      endcase
    end
  end

  tccd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_frame      (push_frame)
  );

  tccd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_frame (push_frame),
    .pop        (q_pop),
    .full       (q_full),
    .avail      (q_avail),
    .head       (head_frame)
  );

  tccd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_avail      (q_avail),
    .q_head       (head_frame),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  // A frame taken from the queue always lands in the output register
  a_pop_to_result: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> result_valid)
    else $error("frame popped but no result presented");

  // A new result only follows a frame taken from the queue
  a_result_from_frame: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid)) |-> $past(q_pop))
    else $error("result appeared without a queued frame");

  // A frame is produced only from a symbol the front has advanced
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (sample_ready && !q_full))
    else $error("frame pushed while the front was held");
`endif

endmodule
